[hw/rtl/lcvc_pkg.sv]
package lcvc_pkg;

  localparam int SampleBits = 24;
  localparam int NetBits    = SampleBits + 1;
  localparam int AccBits    = 40;
  localparam int SpeedBits  = 24;

  localparam logic [2:0] RegForceScale  = 3'd0;
  localparam logic [2:0] RegInverseDrag = 3'd1;
  localparam logic [2:0] RegCoefB0      = 3'd2;
  localparam logic [2:0] RegCoefB1      = 3'd3;
  localparam logic [2:0] RegCoefB2      = 3'd4;
  localparam logic [2:0] RegCoefA1      = 3'd5;
  localparam logic [2:0] RegCoefA2      = 3'd6;
  localparam logic [2:0] RegSmoothAlpha = 3'd7;

  localparam logic signed [SampleBits-1:0] TareReset = SampleBits'(142739);
  localparam logic signed [AccBits-1:0] Sat40Max = {1'b0, {(AccBits-1){1'b1}}};
  localparam logic signed [AccBits-1:0] Sat40Min = {1'b1, {(AccBits-1){1'b0}}};

  typedef struct packed {
    logic signed [SampleBits-1:0] raw;
    logic signed [NetBits-1:0]    net;
    logic                         tared;
  } front_word_t;

  typedef struct packed {
    logic [31:0] force_scale;
    logic [31:0] inverse_drag;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic [15:0] alpha;
  } cfg_t;

  function automatic logic signed [AccBits-1:0] sat40(input logic signed [71:0] x);
    logic signed [71:0] mx;
    logic signed [71:0] mn;
    mx = 72'(Sat40Max);
    mn = 72'(Sat40Min);
    if (x > mx) return Sat40Max;
    if (x < mn) return Sat40Min;
    return x[AccBits-1:0];
  endfunction

endpackage

[hw/rtl/lcvc_front.sv]
module lcvc_front import lcvc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic                         button_i,
  input  logic                         zero_i,
  output logic                         fw_valid_o,
  input  logic                         fw_ready_i,
  output front_word_t                  fw_o
);

  logic signed [SampleBits-1:0] hist_q [3];
  logic signed [SampleBits-1:0] hist_d [3];
  logic [1:0] cnt_q, cnt_d, pos_q, pos_d;
  logic prev_q;
  logic signed [SampleBits-1:0] tare_q, tare_d;
  logic valid_q;
  front_word_t word_q, word_d;
  logic signed [SampleBits-1:0] a, b, c, t, raw;
  logic tare;
  logic acc;

  assign in_ready_o = !valid_q || fw_ready_i;
  assign acc = in_valid_i && in_ready_o;
  assign fw_valid_o = valid_q;
  assign fw_o = word_q;

  always_comb begin
    hist_d = hist_q;
    hist_d[pos_q] = sample_i;
    pos_d = (pos_q == 2'd2) ? 2'd0 : pos_q + 2'd1;
    cnt_d = (cnt_q == 2'd3) ? cnt_q : cnt_q + 2'd1;
    t = '0;
    a = hist_d[0];
    b = hist_d[1];
    c = hist_d[2];
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      b = c;
    end
    if (a > b) begin
      b = a;
    end
    raw = (cnt_d == 2'd3) ? b : sample_i;
    tare = (prev_q && !button_i) || zero_i;
    tare_d = tare ? raw : tare_q;
    if (tare) begin
      hist_d[0] = '0;
      hist_d[1] = '0;
      hist_d[2] = '0;
      cnt_d = '0;
      pos_d = '0;
    end
    word_d.raw   = raw;
    word_d.net   = NetBits'(raw) - NetBits'(tare_d);
    word_d.tared = tare;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '{default: '0};
      cnt_q <= '0;
      pos_q <= '0;
      prev_q <= 1'b1;
      tare_q <= TareReset;
      valid_q <= 1'b0;
    end else begin
      if (acc) begin
        hist_q <= hist_d;
        cnt_q <= cnt_d;
        pos_q <= pos_d;
        prev_q <= button_i;
        tare_q <= tare_d;
        valid_q <= 1'b1;
      end else if (fw_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      word_q <= word_d;
    end
  end

endmodule

[hw/rtl/lcvc_back.sv]
module lcvc_back import lcvc_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         fw_valid_i,
  output logic                         fw_ready_o,
  input  front_word_t                  fw_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SampleBits-1:0] raw_o,
  output logic signed [NetBits-1:0]    net_o,
  output logic [31:0]                  force_o,
  output logic [SpeedBits-1:0]         inst_o,
  output logic [SpeedBits-1:0]         smooth_o,
  output logic                         tared_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_X, S_B0, S_B1, S_A1, S_B2, S_A2, S_QI, S_QF,
    S_SQ, S_AVG, S_OUT
  } state_e;

  state_e state_q;
  logic signed [AccBits-1:0] d1_q, d2_q, x_q, y_q, nz1_q;
  logic [SpeedBits-1:0] avg_q;
  logic seeded_q;
  logic signed [71:0] acc_q;
  logic signed [71:0] prod;
  logic signed [71:0] p0_q;
  front_word_t w_q;
  logic [SpeedBits-1:0] vi_q, vf_q;
  logic [31:0] root_q;
  logic [5:0] it_q;
  logic sel_q;
  logic signed [AccBits:0] mop_a;
  logic signed [32:0] mop_b;

  // shared multiplier, 41 x 33 signed
  assign prod = 72'(mop_a) * 72'(mop_b);

  function automatic logic [31:0] clip32(input logic signed [AccBits-1:0] v);
    if (v < 0) return '0;
    if (v > 40'sh00FFFFFFFF) return 32'hFFFFFFFF;
    return v[31:0];
  endfunction

  logic [31:0] fsel;
  logic [63:0] qv;
  logic signed [25:0] dlt;
  logic signed [42:0] dprod;
  logic signed [26:0] anew;

  always_comb begin
    mop_a = '0;
    mop_b = '0;
    fsel = clip32(sel_q ? y_q : x_q);
    case (state_q)
      S_X: begin
        mop_a = 41'(w_q.net);
        mop_b = {1'b0, cfg_i.force_scale};
      end
      S_B0: begin mop_a = 41'(x_q); mop_b = 33'(cfg_i.b0); end
      S_B1: begin mop_a = 41'(x_q); mop_b = 33'(cfg_i.b1); end
      S_A1: begin mop_a = 41'(y_q); mop_b = 33'(cfg_i.a1); end
      S_B2: begin mop_a = 41'(x_q); mop_b = 33'(cfg_i.b2); end
      S_A2: begin mop_a = 41'(y_q); mop_b = 33'(cfg_i.a2); end
      S_QI, S_QF: begin
        mop_a = {9'd0, fsel};
        mop_b = {1'b0, cfg_i.inverse_drag};
      end
      default: begin end
    endcase
    qv = 64'(prod >>> 8);
    if (qv < 64'd4) qv = 64'd4;
    dlt = 26'(vf_q) - 26'(avg_q);
    dprod = 43'(dlt) * 43'($signed({1'b0, cfg_i.alpha}));
    anew = 27'(avg_q) + 27'(dprod >>> 16);
  end

  // bit-serial square root: rem_q holds the remainder, opnd_q the operand
  logic [33:0] rem_q;
  logic [63:0] opnd_q;
  logic [33:0] rem_sh;
  always_comb begin
    rem_sh = {rem_q[31:0], opnd_q[63:62]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      d1_q <= '0;
      d2_q <= '0;
      x_q <= '0;
      y_q <= '0;
      nz1_q <= '0;
      acc_q <= '0;
      p0_q <= '0;
      w_q <= '0;
      opnd_q <= '0;
      rem_q <= '0;
      root_q <= '0;
      it_q <= '0;
      avg_q <= '0;
      seeded_q <= 1'b0;
      out_valid_o <= 1'b0;
      sel_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (fw_valid_i) begin
            w_q <= fw_i;
            if (fw_i.tared) begin
              d1_q <= '0;
              d2_q <= '0;
              seeded_q <= 1'b0;
            end
            state_q <= S_X;
          end
        end
        S_X: begin
          x_q <= sat40(prod >>> 8);
          state_q <= S_B0;
        end
        S_B0: begin
          y_q <= sat40((prod >>> 30) + 72'(d1_q));
          state_q <= S_B1;
        end
        S_B1: begin
          acc_q <= (prod >>> 30) + 72'(d2_q);
          state_q <= S_A1;
        end
        S_A1: begin
          nz1_q <= sat40(acc_q - (prod >>> 30));
          state_q <= S_B2;
        end
        S_B2: begin
          p0_q <= prod >>> 30;
          state_q <= S_A2;
        end
        S_A2: begin
          d2_q <= sat40(p0_q - (prod >>> 30));
          d1_q <= nz1_q;
          sel_q <= 1'b0;
          state_q <= S_QI;
        end
        S_QI, S_QF: begin
          opnd_q <= qv;
          rem_q <= '0;
          root_q <= '0;
          it_q <= '0;
          state_q <= S_SQ;
        end
        S_SQ: begin
          if (rem_sh >= {root_q, 2'b01}) begin
            rem_q <= rem_sh - {root_q, 2'b01};
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            root_q <= {root_q[30:0], 1'b0};
          end
          opnd_q <= {opnd_q[61:0], 2'b00};
          it_q <= it_q + 6'd1;
          if (it_q == 6'd31) begin
            state_q <= sel_q ? S_AVG : S_QF;
            sel_q <= 1'b1;
          end
        end
        S_AVG: begin
          state_q <= S_OUT;
          out_valid_o <= 1'b1;
          if (!seeded_q) begin
            avg_q <= vf_q;
            seeded_q <= 1'b1;
          end else if (anew < 0) begin
            avg_q <= '0;
          end else if (anew > 27'sd16777215) begin
            avg_q <= '1;
          end else begin
            avg_q <= anew[SpeedBits-1:0];
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // capture roots as they finish
  always_ff @(posedge clk_i) begin
    if (state_q == S_SQ && it_q == 6'd31) begin
      if (!sel_q) vi_q <= (rem_sh >= {root_q, 2'b01} || root_q[31:23] != 0) ?
          ((root_q[30:23] != 0) ? '1 : {root_q[22:0], rem_sh >= {root_q, 2'b01}}) :
          {root_q[22:0], 1'b0};
      else vf_q <= (root_q[30:23] != 0) ? '1 : {root_q[22:0], rem_sh >= {root_q, 2'b01}};
    end
  end

  assign fw_ready_o = (state_q == S_IDLE);
  assign raw_o = w_q.raw;
  assign net_o = w_q.net;
  assign force_o = clip32(y_q);
  assign inst_o = vi_q;
  assign smooth_o = avg_q;
  assign tared_o = w_q.tared;

endmodule

[hw/rtl/load_cell_velocity_conditioner_unit.sv]
// load-cell velocity conditioner
// input stream: one word per converter sample, tdata = {zero_request,
// button_level, sample[23:0]} from the lowest bit, tdata 32 bits
// output stream: one word per input word, same order, tdata holds
// filtered_raw, net_count, force_lowpassed, speed_instant,
// speed_smoothed, tared packed from bit 0, 136 bits
// configuration: write cfg_we_i with register index and data, only while idle
// the front stage takes the median, tare decision and net count combinationally
// and parks the word in a one-entry queue; the back stage runs the force
// scale, the biquad and both square roots on one shared multiplier and a
// bit-serial root (32 steps each)
// with the back stage idle a result is valid once its input word has run through
// the force scale, the biquad and both roots; the back stage takes no new word
// until the receiver has accepted the result of the last one
// the front accepts the next word while the back is busy only if its queue is empty
// reset restores the control registers, clears filters and loads the default tare
// a stalled receiver holds the result and the back stage waits
module load_cell_velocity_conditioner_unit import lcvc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // sample, button_level, zero_request
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // filtered_raw, net_count, force_lowpassed,
                                       // speed_instant, speed_smoothed, tared
);

  cfg_t cfg_q;
  logic fw_valid, fw_ready;
  front_word_t fw;
  logic signed [SampleBits-1:0] raw;
  logic signed [NetBits-1:0] net;
  logic [31:0] frc;
  logic [SpeedBits-1:0] vi, vs;
  logic tared;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.force_scale  <= 32'd98055;
      cfg_q.inverse_drag <= 32'd11438077;
      cfg_q.b0 <= 32'sd21564349;
      cfg_q.b1 <= 32'sd43128698;
      cfg_q.b2 <= 32'sd21564349;
      cfg_q.a1 <= -32'sd1676130431;
      cfg_q.a2 <= 32'sd688645951;
      cfg_q.alpha <= 16'd9830;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegForceScale:  cfg_q.force_scale <= cfg_data_i;
        RegInverseDrag: cfg_q.inverse_drag <= cfg_data_i;
        RegCoefB0:      cfg_q.b0 <= cfg_data_i;
        RegCoefB1:      cfg_q.b1 <= cfg_data_i;
        RegCoefB2:      cfg_q.b2 <= cfg_data_i;
        RegCoefA1:      cfg_q.a1 <= cfg_data_i;
        RegCoefA2:      cfg_q.a2 <= cfg_data_i;
        RegSmoothAlpha: cfg_q.alpha <= cfg_data_i[15:0];
        default: begin end
      endcase
    end
  end

  lcvc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sample_i(s_axis_tdata[23:0]), .button_i(s_axis_tdata[24]),
    .zero_i(s_axis_tdata[25]),
    .fw_valid_o(fw_valid), .fw_ready_i(fw_ready), .fw_o(fw)
  );

  lcvc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .fw_valid_i(fw_valid), .fw_ready_o(fw_ready), .fw_i(fw),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .raw_o(raw), .net_o(net), .force_o(frc), .inst_o(vi), .smooth_o(vs),
    .tared_o(tared)
  );

  assign m_axis_tdata = {6'd0, tared, vs, vi, frc, net, raw};

  logic unused_in;
  assign unused_in = ^s_axis_tdata[31:26];

  a_tared_net: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[129] |-> m_axis_tdata[48:24] == '0)
    else $error("tare word with nonzero net");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");
  a_fw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fw_valid && !fw_ready |=> fw_valid)
    else $error("queue word lost");

endmodule

[tb/sv/tb_load_cell_velocity_conditioner_unit.sv]
module tb_load_cell_velocity_conditioner_unit;
  import lcvc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] filtered_raw;
    logic [24:0] net_count;
    logic [31:0] force_lowpassed;
    logic [23:0] speed_instant;
    logic [23:0] speed_smoothed;
    logic        tared;
  } cond_word_t;

  class conditioner_scoreboard;
    logic [31:0] cfg_reg [8];
    longint hist [3];
    int unsigned hist_count, hist_pos;
    bit prev_btn;
    longint offset, z1, z2;
    longint avg;
    bit seeded;
    cond_word_t pending_words [$];
    int unsigned errors;

    function void restart();
      cfg_reg[RegForceScale]  = 32'd98055;
      cfg_reg[RegInverseDrag] = 32'd11438077;
      cfg_reg[RegCoefB0]      = 32'd21564349;
      cfg_reg[RegCoefB1]      = 32'd43128698;
      cfg_reg[RegCoefB2]      = 32'd21564349;
      cfg_reg[RegCoefA1]      = 32'(-1676130431);
      cfg_reg[RegCoefA2]      = 32'd688645951;
      cfg_reg[RegSmoothAlpha] = 32'd9830;
      clear_chain();
      prev_btn = 1'b1;
      offset = 142739;
      errors = 0;
    endfunction

    function void clear_chain();
      hist[0] = 0; hist[1] = 0; hist[2] = 0;
      hist_count = 0;
      hist_pos = 0;
      z1 = 0;
      z2 = 0;
      avg = 0;
      seeded = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      cfg_reg[idx] = (idx == RegSmoothAlpha) ? {16'd0, val[15:0]} : val;
    endfunction

    function longint clamp_acc(longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813888) return -64'sd549755813888;
      return v;
    endfunction

    function longint coef_mul(logic [31:0] c, longint v);
      logic signed [127:0] p;
      p = 128'(signed'(c)) * 128'(v);
      p = p >>> 30;
      return longint'(p);
    endfunction

    function longint root_speed(longint frc);
      logic [63:0] f, q, x, r, b;
      if (frc < 0) f = 0;
      else if (frc > 64'sd4294967295) f = 64'd4294967295;
      else f = 64'(frc);
      q = (f * {32'd0, cfg_reg[RegInverseDrag]}) >> 8;
      if (q < 4) q = 4;
      x = q;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (r > 64'd16777215) r = 64'd16777215;
      return longint'(r);
    endfunction

    function void note_sample(logic [31:0] w);
      longint s, a, b, c, t, raw, net, x, y, n1, n2, vi, vf, d;
      bit btn, zr, tr;
      cond_word_t e;
      s = longint'(signed'(w[23:0]));
      btn = w[24];
      zr = w[25];
      tr = 0;
      hist[hist_pos] = s;
      hist_pos = (hist_pos + 1) % 3;
      if (hist_count < 3) hist_count++;
      raw = s;
      if (hist_count >= 3) begin
        a = hist[0]; b = hist[1]; c = hist[2];
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin b = c; end
        if (a > b) b = a;
        raw = b;
      end
      if ((prev_btn && !btn) || zr) begin
        offset = raw;
        clear_chain();
        tr = 1;
      end
      prev_btn = btn;
      net = raw - offset;
      x = clamp_acc((net * longint'({32'd0, cfg_reg[RegForceScale]})) >>> 8);
      y = clamp_acc(coef_mul(cfg_reg[RegCoefB0], x) + z1);
      n1 = clamp_acc(coef_mul(cfg_reg[RegCoefB1], x) - coef_mul(cfg_reg[RegCoefA1], y) + z2);
      n2 = clamp_acc(coef_mul(cfg_reg[RegCoefB2], x) - coef_mul(cfg_reg[RegCoefA2], y));
      z1 = n1;
      z2 = n2;
      vi = root_speed(x);
      vf = root_speed(y);
      if (!seeded) begin
        avg = vf;
        seeded = 1;
      end else begin
        d = vf - avg;
        avg = avg + ((d * longint'(cfg_reg[RegSmoothAlpha][15:0])) >>> 16);
        if (avg < 0) avg = 0;
        if (avg > 16777215) avg = 16777215;
      end
      e.filtered_raw = raw[23:0];
      e.net_count = net[24:0];
      e.force_lowpassed = (y < 0) ? 32'd0 : (y > 64'sd4294967295 ? 32'hFFFFFFFF : y[31:0]);
      e.speed_instant = vi[23:0];
      e.speed_smoothed = avg[23:0];
      e.tared = tr;
      pending_words.push_back(e);
    endfunction

    function void check_word(logic [135:0] d);
      cond_word_t e;
      if (pending_words.size() == 0) begin
        $error("unexpected output word %h", d);
        errors++;
        return;
      end
      e = pending_words.pop_front();
      if (d[23:0] !== e.filtered_raw) begin
        $error("filtered_raw exp %h got %h", e.filtered_raw, d[23:0]); errors++;
      end
      if (d[48:24] !== e.net_count) begin
        $error("net_count exp %h got %h", e.net_count, d[48:24]); errors++;
      end
      if (d[80:49] !== e.force_lowpassed) begin
        $error("force_lowpassed exp %h got %h", e.force_lowpassed, d[80:49]); errors++;
      end
      if (d[104:81] !== e.speed_instant) begin
        $error("speed_instant exp %h got %h", e.speed_instant, d[104:81]); errors++;
      end
      if (d[128:105] !== e.speed_smoothed) begin
        $error("speed_smoothed exp %h got %h", e.speed_smoothed, d[128:105]); errors++;
      end
      if (d[129] !== e.tared) begin
        $error("tared exp %b got %b", e.tared, d[129]); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;   // sample, button_level, zero_request
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;        // filtered_raw, net_count, force_lowpassed,
                                     // speed_instant, speed_smoothed, tared

  conditioner_scoreboard board = new();
  int unsigned quiet_cycles = 0;
  bit btn_level = 1'b1;

  always #1 clk_i = ~clk_i;

  load_cell_velocity_conditioner_unit dut (.*);

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern
  int unsigned stall_mode = 0, stall_left = 0, stall_tick = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 600);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= (stall_tick % 7) < 2;
      default: m_axis_tready <= ((stall_tick / 23) % 2) == 0;
    endcase
  end

  task automatic send_word(logic [31:0] w);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_sample(w);
  endtask

  task automatic pause_sender(int unsigned n);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= $urandom;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    pause_sender(0);
    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pack_in(logic [23:0] s, bit b, bit z);
    return {6'($urandom), z, b, s};
  endfunction

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
      2: return 24'(142739 + $urandom_range(0, 4000) - 2000);
      default: return 24'($urandom_range(0, 600000) - 100000);
    endcase
  endfunction

  initial begin
    logic [31:0] vals [8];
    bit zr;
    int unsigned sent, burst;
    board.restart();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed words under reset settings
    send_word(pack_in(24'h7FFFFF, 1, 0));
    send_word(pack_in(24'h800000, 1, 0));
    send_word(pack_in(24'h000000, 1, 0));
    send_word(pack_in(24'hFFFFFF, 1, 0));
    send_word(pack_in(24'h7FFFFF, 1, 0));
    send_word(pack_in(24'd200000, 0, 0));
    send_word(pack_in(24'd300000, 0, 0));
    send_word(pack_in(24'd400000, 1, 0));
    send_word(pack_in(24'd350000, 1, 1));
    send_word(pack_in(24'd500000, 0, 1));
    send_word(pack_in(24'd520000, 1, 0));
    send_word(pack_in(24'd900000, 1, 0));
    send_word(pack_in(24'h7FFFFF, 1, 0));
    send_word(pack_in(24'h7FFFFF, 1, 0));
    send_word(pack_in(24'h800000, 1, 0));
    send_word(pack_in(24'h800000, 1, 0));
    send_word(pack_in(24'h800000, 0, 1));
    send_word(pack_in(24'h7FFFFF, 0, 0));
    send_word(pack_in(24'h7FFFFF, 0, 0));
    send_word(pack_in(24'h7FFFFF, 1, 0));

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: vals = '{32'd0, 32'd0, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'hFFFF0000};
        1: vals = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0000FFFF};
        2: vals = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        3: vals = '{32'd98055, 32'd11438077, 32'd21564349, 32'd43128698, 32'd21564349,
                    32'(-1676130431), 32'd688645951, 32'd9830};
        default: for (int i = 0; i < 8; i++) vals[i] = $urandom;
      endcase
      for (int i = 0; i < 8; i++) write_reg(3'(i), vals[i]);
      sent = 0;
      while (sent < 180) begin
        burst = $urandom_range(1, 25);
        for (int k = 0; k < burst && sent < 180; k++) begin
          if ($urandom_range(0, 19) == 0) btn_level = ~btn_level;
          else if (!btn_level && $urandom_range(0, 2) == 0) btn_level = 1'b1;
          zr = ($urandom_range(0, 49) == 0);
          send_word(pack_in(pick_sample(), btn_level, zr));
          sent++;
        end
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(0, 150));
      end
    end

    drain();
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
